// ===== hw/rtl/comd_pkg.sv =====
`default_nettype none
package comd_pkg;

    typedef struct packed {
        logic        action;
        logic [23:0] center_x;
        logic [23:0] center_y;
        logic [23:0] center_z;
        logic [24:0] side_len;
        logic signed [31:0] node_mass;
        logic [23:0] cell_index;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] cell_value;
        logic signed [31:0] deposited_mass;
        logic [1:0]  status;
    } out_beat_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_MASS = 2'd2;

    localparam logic CFG_FIRST_SLAB = 1'b0;
    localparam logic CFG_SLAB_COUNT = 1'b1;

    localparam logic ACT_DEPOSIT = 1'b0;
    localparam logic ACT_READ    = 1'b1;

endpackage
`default_nettype wire

// ===== hw/rtl/cube_overlap_mass_deposit_unit.sv =====
`default_nettype none
// Cube overlap mass deposit. Deposit beats spread a cube's signed mass over
// the cells it touches in a GRID_N^3 grid memory; read beats return and clear
// one cell. One item in flight at a time. After reset a clearing pass over all
// GRID_N^3 cells zeroes the grid before the first item is taken. A read
// result passes the RRD, RWAIT and DONE states before it is valid. Each axis
// weight is one serial divide; only x columns inside the slab are divided and
// the z weight is redone for every cell written. A node of unit side writes
// 2x2x2 cells. Per-cell writes go through one RAM port.
module cube_overlap_mass_deposit_unit #(
    parameter int GRID_N = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire comd_pkg::in_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output comd_pkg::out_beat_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [8:0]          cfg_data
);
    localparam int CELLS = GRID_N * GRID_N * GRID_N;
    localparam int AW    = $clog2(CELLS);
    localparam int NB    = $clog2(GRID_N);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_RRD   = 13'b0000000000100,
        S_RWAIT = 13'b0000000001000,
        S_XSET  = 13'b0000000010000,
        S_XDIV  = 13'b0000000100000,
        S_YSET  = 13'b0000001000000,
        S_YDIV  = 13'b0000010000000,
        S_ZSET  = 13'b0000100000000,
        S_ZDIV  = 13'b0001000000000,
        S_MUL   = 13'b0010000000000,
        S_RMW   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW:0]   clr_reg, clr_next;
    logic [7:0]    first_reg;
    logic [8:0]    count_reg;
    comd_pkg::in_beat_t item_reg;
    logic          ovalid_reg;
    comd_pkg::out_beat_t obeat_reg, obeat_next;

    logic signed [19:0] xi_reg, xi_next, yi_reg, yi_next, zi_reg, zi_next;
    logic signed [19:0] xhi_reg, yhi_reg, zhi_reg, ylo_reg, zlo_reg;
    logic signed [19:0] xhi_next, yhi_next, zhi_next, ylo_next, zlo_next;
    logic [24:0] fx_reg, fx_next, fy_reg, fy_next, fz_reg, fz_next;
    logic [24:0] fxy_reg, fxy_next;
    logic signed [47:0] sum_reg, sum_next;
    logic [55:0] prod_reg, prod_next;
    logic [1:0]  ph_reg, ph_next;
    logic        bad_reg, bad_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [NB-1:0] rx_reg, rx_next, ry_reg, ry_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    logic          div_start, div_done;
    logic [41:0]   div_num;
    logic [24:0]   div_q;
    logic [25:0]   twolen;
    logic [31:0]   am;

    function automatic logic signed [19:0] floor17(input logic signed [27:0] v);
        floor17 = 20'(v >>> 17);
    endfunction

    function automatic logic signed [20:0] wrapi(input logic signed [19:0] i);
        wrapi = (i == 20'(GRID_N)) ? 21'sd0 : 21'(i);
    endfunction

    function automatic logic [17:0] overlap(input logic [23:0] c, input logic [24:0] len,
                                            input logic signed [19:0] i);
        logic signed [38:0] d;
        logic signed [38:0] ov;
        d  = 39'($signed({1'b0, c, 1'b0})) - (39'(i) <<< 17);
        if (d < 0)
        begin
            d = -d;
        end
        ov = 39'($signed({1'b0, len})) + 39'sd65536 - d;
        if (ov > 39'sd131072)
        begin
            ov = 39'sd131072;
        end
        if (ov > 39'($signed({1'b0, len, 1'b0})))
        begin
            ov = 39'($signed({1'b0, len, 1'b0}));
        end
        if (ov < 0)
        begin
            ov = '0;
        end
        overlap = ov[17:0];
    endfunction

    comd_ram #(.WIDTH(32), .DEPTH(CELLS)) u_grid (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    comd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (twolen),
        .done  (div_done),
        .quot  (div_q)
    );

    assign twolen    = {item_reg.side_len, 1'b0};
    assign am        = item_reg.node_mass[31] ? 32'(-item_reg.node_mass) : item_reg.node_mass;
    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = ovalid_reg;
    assign out_data  = obeat_reg;

    logic signed [27:0] c2x, c2y, c2z;
    logic signed [20:0] ax, ay, az, relx;
    logic [55:0] amt_mag;
    logic signed [32:0] amt;
    logic signed [33:0] cellsum;
    logic [47:0] asum;

    always_comb
    begin
        c2x = 28'($signed({1'b0, item_reg.center_x, 1'b0})) + 28'sd65536;
        c2y = 28'($signed({1'b0, item_reg.center_y, 1'b0})) + 28'sd65536;
        c2z = 28'($signed({1'b0, item_reg.center_z, 1'b0})) + 28'sd65536;
        ax  = wrapi(xi_reg);
        ay  = wrapi(yi_reg);
        az  = wrapi(zi_reg);
        relx = ax - 21'($signed({1'b0, first_reg}));
        amt_mag = prod_reg >> 24;
        amt = item_reg.node_mass[31] ? -$signed({1'b0, amt_mag[31:0]})
                                     : $signed({1'b0, amt_mag[31:0]});
        cellsum = 34'($signed(rdata)) + 34'(amt);
        asum = sum_reg[47] ? 48'(-sum_reg) : 48'(sum_reg);

        state_next = state_reg;
        clr_next   = clr_reg;
        obeat_next = obeat_reg;
        xi_next = xi_reg; yi_next = yi_reg; zi_next = zi_reg;
        xhi_next = xhi_reg; yhi_next = yhi_reg; zhi_next = zhi_reg;
        ylo_next = ylo_reg; zlo_next = zlo_reg;
        fx_next = fx_reg; fy_next = fy_reg; fz_next = fz_reg;
        fxy_next = fxy_reg;
        sum_next = sum_reg; prod_next = prod_reg; ph_next = ph_reg;
        bad_next = bad_reg; addr_next = addr_reg;
        rx_next = rx_reg; ry_next = ry_reg;
        we = 1'b0; waddr = addr_reg; wdata = '0; raddr = addr_reg;
        div_start = 1'b0; div_num = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    obeat_next = '0;
                    sum_next = '0;
                    bad_next = 1'b0;
                    if (in_data.action == comd_pkg::ACT_READ)
                    begin
                        if (25'(in_data.cell_index) < 25'(CELLS))
                        begin
                            addr_next  = in_data.cell_index[AW-1:0];
                            state_next = S_RRD;
                        end
                        else
                        begin
                            obeat_next.status = comd_pkg::ST_BAD;
                            state_next = S_DONE;
                        end
                    end
                    else if (in_data.side_len == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_XSET;
                    end
                end
            end
            S_RRD:
            begin
                raddr = addr_reg;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                obeat_next.cell_value = rdata;
                we = 1'b1; waddr = addr_reg; wdata = '0;
                state_next = S_DONE;
            end
            S_XSET:
            begin
                if (ph_reg == 2'd0)
                begin
                    xi_next  = floor17(c2x - 28'($signed({1'b0, item_reg.side_len})));
                    xhi_next = floor17(c2x + 28'($signed({1'b0, item_reg.side_len})));
                    ylo_next = floor17(c2y - 28'($signed({1'b0, item_reg.side_len})));
                    yhi_next = floor17(c2y + 28'($signed({1'b0, item_reg.side_len})));
                    zlo_next = floor17(c2z - 28'($signed({1'b0, item_reg.side_len})));
                    zhi_next = floor17(c2z + 28'($signed({1'b0, item_reg.side_len})));
                    ph_next  = 2'd1;
                end
                else if (xi_reg > xhi_reg)
                begin
                    ph_next = 2'd0;
                    state_next = S_DONE;
                    if (bad_reg)
                    begin
                        obeat_next.status = comd_pkg::ST_BAD;
                    end
                    else if (64'(asum) * 64'd1000000 > 64'(am) * 64'd1000001)
                    begin
                        obeat_next.status = comd_pkg::ST_MASS;
                    end
                    if (sum_reg > 48'sh7FFFFFFF)
                    begin
                        obeat_next.deposited_mass = 32'sh7FFFFFFF;
                    end
                    else if (sum_reg < -48'sh80000000)
                    begin
                        obeat_next.deposited_mass = 32'sh80000000;
                    end
                    else
                    begin
                        obeat_next.deposited_mass = sum_reg[31:0];
                    end
                end
                else if (ax < 21'($signed({1'b0, first_reg}))
                      || ax >= 21'($signed({1'b0, first_reg})) + 21'($signed({1'b0, count_reg})))
                begin
                    xi_next = xi_reg + 20'sd1;
                end
                else
                begin
                    div_start = 1'b1;
                    div_num = {overlap(item_reg.center_x, item_reg.side_len, xi_reg), 24'd0};
                    state_next = S_XDIV;
                end
            end
            S_XDIV:
            begin
                if (div_done)
                begin
                    fx_next = div_q;
                    rx_next = relx[NB-1:0];
                    yi_next = ylo_reg;
                    state_next = S_YSET;
                end
            end
            S_YSET:
            begin
                if (yi_reg > yhi_reg)
                begin
                    xi_next = xi_reg + 20'sd1;
                    state_next = S_XSET;
                end
                else if (relx >= 21'(GRID_N) || ay < 0 || ay >= 21'(GRID_N))
                begin
                    bad_next = 1'b1;
                    yi_next = yi_reg + 20'sd1;
                end
                else
                begin
                    div_start = 1'b1;
                    div_num = {overlap(item_reg.center_y, item_reg.side_len, yi_reg), 24'd0};
                    state_next = S_YDIV;
                end
            end
            S_YDIV:
            begin
                if (div_done)
                begin
                    fy_next = div_q;
                    ry_next = ay[NB-1:0];
                    ph_next = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_ZSET:
            begin
                if (zi_reg > zhi_reg)
                begin
                    yi_next = yi_reg + 20'sd1;
                    state_next = S_YSET;
                end
                else if (az < 0 || az >= 21'(GRID_N))
                begin
                    bad_next = 1'b1;
                    zi_next = zi_reg + 20'sd1;
                end
                else
                begin
                    div_start = 1'b1;
                    div_num = {overlap(item_reg.center_z, item_reg.side_len, zi_reg), 24'd0};
                    addr_next = AW'((32'(rx_reg) * 32'(GRID_N) + 32'(ry_reg)) * 32'(GRID_N)
                                    + 32'(az[NB-1:0]));
                    state_next = S_ZDIV;
                end
            end
            S_ZDIV:
            begin
                if (div_done)
                begin
                    fz_next = div_q;
                    ph_next = 2'd2;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        prod_next = 56'(fx_reg) * 56'(fy_reg);
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        fxy_next = prod_reg[48:24];
                        zi_next = zlo_reg;
                        state_next = S_ZSET;
                    end
                    2'd2:
                    begin
                        prod_next = 56'(fxy_reg) * 56'(fz_reg);
                        ph_next = 2'd3;
                    end
                    default:
                    begin
                        prod_next = 56'(am) * 56'(prod_reg[48:24]);
                        ph_next = 2'd1;
                        raddr = addr_reg;
                        state_next = S_RMW;
                    end
                endcase
            end
            S_RMW:
            begin
                we = 1'b1;
                waddr = addr_reg;
                if (cellsum > 34'sh7FFFFFFF)
                begin
                    wdata = 32'h7FFFFFFF;
                end
                else if (cellsum < -34'sh80000000)
                begin
                    wdata = 32'h80000000;
                end
                else
                begin
                    wdata = cellsum[31:0];
                end
                sum_next = sum_reg + 48'(amt);
                zi_next = zi_reg + 20'sd1;
                state_next = S_ZSET;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            first_reg  <= 8'd0;
            count_reg  <= 9'd32;
            ovalid_reg <= 1'b0;
            ph_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ph_reg    <= ph_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == comd_pkg::CFG_FIRST_SLAB)
                begin
                    first_reg <= cfg_data[7:0];
                end
                else
                begin
                    count_reg <= cfg_data;
                end
            end
            if (state_reg == S_DONE)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        obeat_reg <= obeat_next;
        xi_reg <= xi_next; yi_reg <= yi_next; zi_reg <= zi_next;
        xhi_reg <= xhi_next; yhi_reg <= yhi_next; zhi_reg <= zhi_next;
        ylo_reg <= ylo_next; zlo_reg <= zlo_next;
        fx_reg <= fx_next; fy_reg <= fy_next; fz_reg <= fz_next;
        fxy_reg <= fxy_next;
        sum_reg <= sum_next; prod_reg <= prod_next;
        bad_reg <= bad_next; addr_reg <= addr_next;
        rx_reg <= rx_next; ry_reg <= ry_next;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("input taken while busy");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid)
        else $error("result lost");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !we)
        else $error("grid written while idle");

endmodule
`default_nettype wire

// ===== hw/rtl/comd_ram.sv =====
`default_nettype none
module comd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/comd_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle while busy: q = num / den, 42-bit num, 26-bit den.
module comd_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [41:0] num,
    input  wire logic [25:0] den,
    output logic             done,
    output logic [24:0]      quot
);
    logic [5:0]  cnt_reg, cnt_next;
    logic [41:0] q_reg, q_next;
    logic [26:0] r_reg, r_next;
    logic [25:0] d_reg, d_next;
    logic        busy_reg, busy_next;
    logic [26:0] trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        trial     = {r_reg[25:0], q_reg[41]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[26])
            begin
                r_next = trial;
            end
            else
            begin
                r_next = {r_reg[25:0], q_reg[41]};
            end
            q_next   = {q_reg[40:0], ~trial[26]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd41)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quot = q_next[24:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule
`default_nettype wire
